/* design/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and character codes for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

	// decode modes
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_ESC  = 2'd1;
	localparam logic [1:0] MODE_OCT  = 2'd2;
	localparam logic [1:0] MODE_HEX  = 2'd3;

	localparam int MAX_RES = 3;

	localparam logic [15:0] NL_MAX = 16'hFFFF;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BKSP   = 8'h08;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_N   = 8'h6E;
	localparam logic [7:0] CH_LO_R   = 8'h72;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_UP_T   = 8'h54;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        string_end;
		logic        last_of_run;
		logic [15:0] newline_total;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        string_end;
		logic [15:0] newline_total;
	} res_t;

	// all results caused by one input word
	typedef struct packed {
		logic [1:0]               cnt;
		res_t [MAX_RES-1:0]       res;
	} bundle_t;

endpackage

/* design/sed_word_if.sv */
// ----------------------------------------------------------------------------
// sed_word_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface sed_word_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/string_escape_decoder.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes a quoted string body byte by byte: escapes, octal/hex runs,
// closing quote, end-of-input flush and a saturating raw newline count.
// ----------------------------------------------------------------------------
//  channel | dir | payload            | words per item
//  din     | in  | sed_pkg::in_word_t  | 1
//  dout    | out | sed_pkg::out_word_t | 0 to 3
//
//  An input word is decoded in the cycle it is accepted; its results are
//  registered into a two-entry result queue and leave one word per cycle
//  while dout.ready is high. With dout.ready high, the sustained rate is one
//  input word per cycle while each input yields at most one result.
//  arst_n clears decode state, queue fill and pointers.
//  din.ready drops only while the result queue holds two pending items.
// ----------------------------------------------------------------------------
module string_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	sed_word_if.sink    din,
	sed_word_if.source  dout
);

	logic [1:0]  mode_q, mode_d;
	logic [7:0]  val_q, val_d;
	logic [1:0]  dcnt_q, dcnt_d;
	logic [15:0] nl_q, nl_d;

	sed_pkg::bundle_t bnd;
	sed_pkg::bundle_t fifo_q [2];
	sed_pkg::bundle_t head;
	logic [1:0]  fill_q;
	logic        wr_q, rd_q;
	logic [1:0]  idx_q;
	logic        acc_in, push, pop, last;

	function automatic sed_pkg::res_t mk(input logic [7:0] v, input logic bv,
			input logic se, input logic [15:0] nl);
		sed_pkg::res_t r;
		r.out_byte      = bv ? v : 8'd0;
		r.byte_valid    = bv;
		r.string_end    = se;
		r.newline_total = nl;
		return r;
	endfunction

	// decode
	always_comb begin
		logic [7:0] b;
		logic       eoi;
		logic       fl;
		logic       pl;
		logic [7:0] fl_val;
		logic [1:0] fl_cnt;
		logic [7:0] hv;
		logic       is_hex;
		logic       is_oct;
		logic [1:0] n;

		b      = din.data.data_byte;
		eoi    = din.data.end_of_input;
		mode_d = mode_q;
		val_d  = val_q;
		dcnt_d = dcnt_q;
		nl_d   = nl_q;
		bnd    = '0;
		n      = 2'd0;
		fl     = 1'b0;
		pl     = 1'b0;
		fl_val = val_q;
		fl_cnt = dcnt_q;

		is_oct = (b >= sed_pkg::CH_ZERO) && (b <= sed_pkg::CH_SEVEN);
		is_hex = 1'b1;
		hv     = 8'd0;
		priority if ((b >= sed_pkg::CH_ZERO) && (b <= sed_pkg::CH_NINE)) begin
			hv = b - sed_pkg::CH_ZERO;
		end else if ((b >= sed_pkg::CH_LO_A) && (b <= sed_pkg::CH_LO_F)) begin
			hv = b - sed_pkg::CH_LO_A + 8'd10;
		end else if ((b >= sed_pkg::CH_UP_A) && (b <= sed_pkg::CH_UP_F)) begin
			hv = b - sed_pkg::CH_UP_A + 8'd10;
		end else begin
			is_hex = 1'b0;
		end

		if (eoi) begin
			fl = 1'b1;
		end else begin
			unique case (mode_q)
				sed_pkg::MODE_TEXT: begin
					pl = 1'b1;
				end
				sed_pkg::MODE_ESC: begin
					mode_d = sed_pkg::MODE_TEXT;
					unique case (b)
						sed_pkg::CH_LO_A, sed_pkg::CH_UP_A: begin
							bnd.res[n] = mk(sed_pkg::CH_BKSP, 1'b1, 1'b0, nl_d);
							n = n + 2'd1;
						end
						sed_pkg::CH_LO_N: begin
							bnd.res[n] = mk(sed_pkg::CH_LF, 1'b1, 1'b0, nl_d);
							n = n + 2'd1;
						end
						sed_pkg::CH_LO_R: begin
							bnd.res[n] = mk(sed_pkg::CH_CR, 1'b1, 1'b0, nl_d);
							n = n + 2'd1;
						end
						sed_pkg::CH_LO_T, sed_pkg::CH_UP_T: begin
							bnd.res[n] = mk(sed_pkg::CH_TAB, 1'b1, 1'b0, nl_d);
							n = n + 2'd1;
						end
						sed_pkg::CH_BSLASH, sed_pkg::CH_QUOTE: begin
							bnd.res[n] = mk(b, 1'b1, 1'b0, nl_d);
							n = n + 2'd1;
						end
						sed_pkg::CH_LO_X: begin
							mode_d = sed_pkg::MODE_HEX;
							val_d  = 8'd0;
							dcnt_d = 2'd0;
						end
						default: begin
							if (is_oct) begin
								mode_d = sed_pkg::MODE_OCT;
								val_d  = {5'd0, b[2:0]};
								dcnt_d = 2'd1;
							end else begin
								// unknown escape kept literally
								bnd.res[n] = mk(sed_pkg::CH_BSLASH, 1'b1, 1'b0, nl_d);
								n = n + 2'd1;
								bnd.res[n] = mk(b, 1'b1, 1'b0, nl_d);
								n = n + 2'd1;
							end
						end
					endcase
				end
				sed_pkg::MODE_OCT: begin
					if (is_oct) begin
						fl_val = {val_q[4:0], b[2:0]};
						fl_cnt = dcnt_q + 2'd1;
						val_d  = fl_val;
						dcnt_d = fl_cnt;
						fl     = (dcnt_q == 2'd2);
					end else begin
						fl = 1'b1;
						pl = 1'b1;
					end
				end
				sed_pkg::MODE_HEX: begin
					if (is_hex) begin
						fl_val = {val_q[3:0], hv[3:0]};
						fl_cnt = dcnt_q + 2'd1;
						val_d  = fl_val;
						dcnt_d = fl_cnt;
						fl     = (dcnt_q == 2'd1);
					end else begin
						fl = 1'b1;
						pl = 1'b1;
					end
				end
				default: begin
					pl = 1'b1;
				end
			endcase
		end

		if (fl) begin
			unique case (mode_q)
				sed_pkg::MODE_ESC: begin
					bnd.res[n] = mk(sed_pkg::CH_BSLASH, 1'b1, 1'b0, nl_d);
					n = n + 2'd1;
				end
				sed_pkg::MODE_OCT: begin
					bnd.res[n] = mk(fl_val, 1'b1, 1'b0, nl_d);
					n = n + 2'd1;
				end
				sed_pkg::MODE_HEX: begin
					if (fl_cnt == 2'd0) begin
						bnd.res[n] = mk(sed_pkg::CH_BSLASH, 1'b1, 1'b0, nl_d);
						n = n + 2'd1;
						bnd.res[n] = mk(sed_pkg::CH_LO_X, 1'b1, 1'b0, nl_d);
						n = n + 2'd1;
					end else begin
						bnd.res[n] = mk(fl_val, 1'b1, 1'b0, nl_d);
						n = n + 2'd1;
					end
				end
				default: begin
				end
			endcase
			mode_d = sed_pkg::MODE_TEXT;
			val_d  = 8'd0;
			dcnt_d = 2'd0;
		end

		if (pl) begin
			priority if (b == sed_pkg::CH_QUOTE) begin
				bnd.res[n] = mk(8'd0, 1'b0, 1'b1, nl_d);
				n = n + 2'd1;
				mode_d = sed_pkg::MODE_TEXT;
				val_d  = 8'd0;
				dcnt_d = 2'd0;
				nl_d   = 16'd0;
			end else if (b == sed_pkg::CH_BSLASH) begin
				mode_d = sed_pkg::MODE_ESC;
			end else begin
				if ((b == sed_pkg::CH_LF) && (nl_d != sed_pkg::NL_MAX)) begin
					nl_d = nl_d + 16'd1;
				end
				bnd.res[n] = mk(b, 1'b1, 1'b0, nl_d);
				n = n + 2'd1;
			end
		end

		if (eoi) begin
			bnd.res[n] = mk(8'd0, 1'b0, 1'b1, nl_d);
			n = n + 2'd1;
			mode_d = sed_pkg::MODE_TEXT;
			val_d  = 8'd0;
			dcnt_d = 2'd0;
			nl_d   = 16'd0;
		end

		bnd.cnt = n;
	end

	// result queue
	assign din.ready = (fill_q != 2'd2);
	assign acc_in    = din.valid && din.ready;
	assign push      = acc_in && (bnd.cnt != 2'd0);
	assign head      = fifo_q[rd_q];
	assign last      = (idx_q == (head.cnt - 2'd1));
	assign pop       = dout.valid && dout.ready && last;

	assign dout.valid              = (fill_q != 2'd0);
	assign dout.data.out_byte      = head.res[idx_q].out_byte;
	assign dout.data.byte_valid    = head.res[idx_q].byte_valid;
	assign dout.data.string_end    = head.res[idx_q].string_end;
	assign dout.data.last_of_run   = last;
	assign dout.data.newline_total = head.res[idx_q].newline_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sed_pkg::MODE_TEXT;
			val_q  <= 8'd0;
			dcnt_q <= 2'd0;
			nl_q   <= 16'd0;
			fill_q <= 2'd0;
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (acc_in) begin
				mode_q <= mode_d;
				val_q  <= val_d;
				dcnt_q <= dcnt_d;
				nl_q   <= nl_d;
			end
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (dout.valid && dout.ready) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= bnd;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result queue overfilled");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> (idx_q < head.cnt))
		else $error("result index beyond item's result count");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.data.string_end) |-> dout.data.last_of_run)
		else $error("string end not on last word of run");

	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready && din.data.end_of_input) |=>
		((mode_q == sed_pkg::MODE_TEXT) && (nl_q == 16'd0) && (dcnt_q == 2'd0)))
		else $error("decoder not idle after end of input");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_escape_decoder. A short table of directed
// words covers the byte extremes, escape forms, end-of-input flushes and the
// closing quote. Random well-formed string bodies with noise follow.
// Every output word is checked against the table's expected words or an in-bench decoder model.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [7:0]         b;
		bit                 eoi;
		int                 n;
		sed_pkg::out_word_t r0;
		sed_pkg::out_word_t r1;
		sed_pkg::out_word_t r2;
	} dir_row_t;

	localparam int N_DIR    = 25;
	localparam int N_RANDOM = 255;

	localparam logic [7:0] ESC_CODES [8] = '{sed_pkg::CH_LO_A, sed_pkg::CH_UP_A,
		sed_pkg::CH_LO_N, sed_pkg::CH_LO_R, sed_pkg::CH_LO_T, sed_pkg::CH_UP_T,
		sed_pkg::CH_BSLASH, sed_pkg::CH_QUOTE};

	logic clk;
	logic arst_n;

	sed_word_if #(.T(sed_pkg::in_word_t))  din_if ();
	sed_word_if #(.T(sed_pkg::out_word_t)) dout_if ();

	string_escape_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	// decoder model state
	logic [1:0]  dec_mode;
	logic [7:0]  esc_acc;
	logic [1:0]  esc_digits;
	logic [15:0] lf_count;

	sed_pkg::out_word_t step_words [$];
	sed_pkg::out_word_t pending_out [$];
	sed_pkg::out_word_t want;
	dir_row_t           dir_tab [N_DIR];

	int errors    = 0;
	int n_words;
	int n_checked = 0;
	int n_closed  = 0;
	int burst_left;
	int rx_cyc    = 0;
	int rx_mode   = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic sed_pkg::out_word_t ow(logic [7:0] b, bit v, bit e, bit l,
			logic [15:0] nl);
		sed_pkg::out_word_t w;
		w.out_byte      = b;
		w.byte_valid    = v;
		w.string_end    = e;
		w.last_of_run   = l;
		w.newline_total = nl;
		return w;
	endfunction

	function automatic void emit(logic [7:0] b, bit v, bit e);
		step_words.insert(step_words.size(), ow(v ? b : 8'h00, v, e, 1'b0, lf_count));
	endfunction

	function automatic void clear_string();
		dec_mode   = sed_pkg::MODE_TEXT;
		esc_acc    = 8'h00;
		esc_digits = 2'd0;
		lf_count   = 16'h0000;
	endfunction

	function automatic void text_byte(logic [7:0] b);
		if (b == sed_pkg::CH_QUOTE) begin
			emit(8'h00, 1'b0, 1'b1);
			clear_string();
		end else if (b == sed_pkg::CH_BSLASH) begin
			dec_mode = sed_pkg::MODE_ESC;
		end else begin
			if (b == sed_pkg::CH_LF && lf_count != sed_pkg::NL_MAX)
				lf_count++;
			emit(b, 1'b1, 1'b0);
		end
	endfunction

	function automatic void flush_escape();
		case (dec_mode)
			sed_pkg::MODE_ESC: emit(sed_pkg::CH_BSLASH, 1'b1, 1'b0);
			sed_pkg::MODE_OCT: emit(esc_acc, 1'b1, 1'b0);
			sed_pkg::MODE_HEX: begin
				if (esc_digits == 2'd0) begin
					emit(sed_pkg::CH_BSLASH, 1'b1, 1'b0);
					emit(sed_pkg::CH_LO_X, 1'b1, 1'b0);
				end else begin
					emit(esc_acc, 1'b1, 1'b0);
				end
			end
			default: ;
		endcase
		dec_mode   = sed_pkg::MODE_TEXT;
		esc_acc    = 8'h00;
		esc_digits = 2'd0;
	endfunction

	function automatic int hex_val(logic [7:0] b);
		if (b >= sed_pkg::CH_ZERO && b <= sed_pkg::CH_NINE)
			return int'(b - sed_pkg::CH_ZERO);
		if (b >= sed_pkg::CH_LO_A && b <= sed_pkg::CH_LO_F)
			return int'(b - sed_pkg::CH_LO_A) + 10;
		if (b >= sed_pkg::CH_UP_A && b <= sed_pkg::CH_UP_F)
			return int'(b - sed_pkg::CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic void after_escape(logic [7:0] b);
		dec_mode = sed_pkg::MODE_TEXT;
		case (b)
			sed_pkg::CH_LO_A, sed_pkg::CH_UP_A: emit(sed_pkg::CH_BKSP, 1'b1, 1'b0);
			sed_pkg::CH_LO_N:                   emit(sed_pkg::CH_LF, 1'b1, 1'b0);
			sed_pkg::CH_LO_R:                   emit(sed_pkg::CH_CR, 1'b1, 1'b0);
			sed_pkg::CH_LO_T, sed_pkg::CH_UP_T: emit(sed_pkg::CH_TAB, 1'b1, 1'b0);
			sed_pkg::CH_BSLASH:                 emit(sed_pkg::CH_BSLASH, 1'b1, 1'b0);
			sed_pkg::CH_QUOTE:                  emit(sed_pkg::CH_QUOTE, 1'b1, 1'b0);
			sed_pkg::CH_LO_X: begin
				dec_mode   = sed_pkg::MODE_HEX;
				esc_acc    = 8'h00;
				esc_digits = 2'd0;
			end
			default: begin
				if (b >= sed_pkg::CH_ZERO && b <= sed_pkg::CH_SEVEN) begin
					dec_mode   = sed_pkg::MODE_OCT;
					esc_acc    = {5'd0, b[2:0]};
					esc_digits = 2'd1;
				end else begin
					emit(sed_pkg::CH_BSLASH, 1'b1, 1'b0);
					emit(b, 1'b1, 1'b0);
				end
			end
		endcase
	endfunction

	// decoded words for one input word land in step_words
	function automatic void decode_step(logic [7:0] b, bit eoi);
		int d;
		step_words.delete();
		if (eoi) begin
			flush_escape();
			emit(8'h00, 1'b0, 1'b1);
			clear_string();
		end else begin
			case (dec_mode)
				sed_pkg::MODE_TEXT: text_byte(b);
				sed_pkg::MODE_ESC:  after_escape(b);
				sed_pkg::MODE_OCT: begin
					if (b >= sed_pkg::CH_ZERO && b <= sed_pkg::CH_SEVEN) begin
						esc_acc = {esc_acc[4:0], b[2:0]};
						esc_digits++;
						if (esc_digits == 2'd3)
							flush_escape();
					end else begin
						flush_escape();
						text_byte(b);
					end
				end
				default: begin
					d = hex_val(b);
					if (d >= 0) begin
						esc_acc = {esc_acc[3:0], d[3:0]};
						esc_digits++;
						if (esc_digits == 2'd2)
							flush_escape();
					end else begin
						flush_escape();
						text_byte(b);
					end
				end
			endcase
		end
		if (step_words.size() != 0)
			step_words[step_words.size() - 1].last_of_run = 1'b1;
	endfunction

	// n_typed < 0: expectation comes from the model
	task automatic send_word(input logic [7:0] b, input bit eoi, input int n_typed,
			input sed_pkg::out_word_t [2:0] typed);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				din_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		din_if.valid <= 1'b1;
		din_if.data  <= '{data_byte: b, end_of_input: eoi};
		@(posedge clk);
		while (!din_if.ready)
			@(posedge clk);
		burst_left--;
		n_words++;
		decode_step(b, eoi);
		if (n_typed < 0) begin
			foreach (step_words[i])
				pending_out.insert(pending_out.size(), step_words[i]);
		end else begin
			for (int i = 0; i < n_typed; i++)
				pending_out.insert(pending_out.size(), typed[i]);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(b, 1'b0, -1, '0);
	endtask

	task automatic send_eoi();
		send_word(8'($urandom_range(0, 255)), 1'b1, -1, '0);
	endtask

	function automatic logic [7:0] pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return sed_pkg::CH_ZERO + 8'(r);
		if (r < 16)
			return sed_pkg::CH_LO_A + 8'(r - 10);
		return sed_pkg::CH_UP_A + 8'(r - 16);
	endfunction

	task automatic random_string();
		int segs;
		int kind;
		int k;
		logic [7:0] b;
		segs = $urandom_range(0, 10);
		for (int s = 0; s < segs; s++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				b = 8'($urandom_range(0, 255));
				if (b == sed_pkg::CH_QUOTE || b == sed_pkg::CH_BSLASH
						|| $urandom_range(0, 5) == 0)
					b = sed_pkg::CH_LF;
				send_byte(b);
			end else if (kind < 55) begin
				send_byte(sed_pkg::CH_BSLASH);
				send_byte(ESC_CODES[3'($urandom_range(0, 7))]);
			end else if (kind < 67) begin
				send_byte(sed_pkg::CH_BSLASH);
				k = $urandom_range(1, 3);
				repeat (k) send_byte(sed_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
			end else if (kind < 79) begin
				send_byte(sed_pkg::CH_BSLASH);
				send_byte(sed_pkg::CH_LO_X);
				k = $urandom_range(0, 2);
				repeat (k) send_byte(pick_hex());
			end else if (kind < 87) begin
				send_byte(sed_pkg::CH_BSLASH);
				send_byte(($urandom_range(0, 3) == 0) ? sed_pkg::CH_LF
					: 8'($urandom_range(0, 255)));
			end else if (kind < 95) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				// input ends with an escape still open
				send_byte(sed_pkg::CH_BSLASH);
				k = $urandom_range(0, 3);
				if (k == 1 || k == 3)
					send_byte(sed_pkg::CH_LO_X);
				if (k == 2)
					send_byte(sed_pkg::CH_ZERO + 8'($urandom_range(0, 7)));
				if (k == 3)
					send_byte(pick_hex());
				send_eoi();
			end
		end
		k = $urandom_range(0, 9);
		if (k < 6)
			send_byte(sed_pkg::CH_QUOTE);
		else if (k < 8)
			send_eoi();
	endtask

	// receiver stall pattern, chosen at random from four modes
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (rx_cyc % 64 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0:       dout_if.ready <= 1'b1;
			1:       dout_if.ready <= 1'($urandom_range(0, 1));
			2:       dout_if.ready <= ($urandom_range(0, 3) != 0);
			default: dout_if.ready <= (rx_cyc % 5 < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && dout_if.valid && dout_if.ready) begin
			if (dout_if.data.string_end)
				n_closed++;
			if (pending_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: byte %02h valid %0b end %0b last %0b nl %0d",
						dout_if.data.out_byte, dout_if.data.byte_valid,
						dout_if.data.string_end, dout_if.data.last_of_run,
						dout_if.data.newline_total);
			end else begin
				want = pending_out.pop_front();
				n_checked++;
				if (dout_if.data.out_byte !== want.out_byte
						|| dout_if.data.byte_valid !== want.byte_valid
						|| dout_if.data.string_end !== want.string_end
						|| dout_if.data.last_of_run !== want.last_of_run
						|| dout_if.data.newline_total !== want.newline_total) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at word %0d: exp byte %02h valid %0b end %0b last %0b nl %0d",
							n_checked, want.out_byte, want.byte_valid, want.string_end,
							want.last_of_run, want.newline_total);
						$display("  got byte %02h valid %0b end %0b last %0b nl %0d",
							dout_if.data.out_byte, dout_if.data.byte_valid,
							dout_if.data.string_end, dout_if.data.last_of_run,
							dout_if.data.newline_total);
					end
				end
			end
		end
	end

	initial begin
		#200_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		din_if.valid  <= 1'b0;
		din_if.data   <= '0;
		n_words    = 0;
		burst_left = 0;
		clear_string();

		dir_tab = '{
			'{sed_pkg::CH_UP_A, 1'b0, 1,
				ow(sed_pkg::CH_UP_A, 1'b1, 1'b0, 1'b1, 16'd0), '0, '0},
			'{8'h00, 1'b0, 1, ow(8'h00, 1'b1, 1'b0, 1'b1, 16'd0), '0, '0},
			'{8'hFF, 1'b0, 1, ow(8'hFF, 1'b1, 1'b0, 1'b1, 16'd0), '0, '0},
			'{sed_pkg::CH_LF, 1'b0, 1,
				ow(sed_pkg::CH_LF, 1'b1, 1'b0, 1'b1, 16'd1), '0, '0},
			'{sed_pkg::CH_BSLASH, 1'b0, 0, '0, '0, '0},
			'{sed_pkg::CH_LO_A, 1'b0, 1,
				ow(sed_pkg::CH_BKSP, 1'b1, 1'b0, 1'b1, 16'd1), '0, '0},
			// backslash-newline is an unknown escape, not counted
			'{sed_pkg::CH_BSLASH, 1'b0, 0, '0, '0, '0},
			'{sed_pkg::CH_LF, 1'b0, 2,
				ow(sed_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 16'd1),
				ow(sed_pkg::CH_LF, 1'b1, 1'b0, 1'b1, 16'd1), '0},
			'{sed_pkg::CH_BSLASH, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_LO_X, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_ZERO + 8'd4, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_UP_F, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_BSLASH, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_ZERO + 8'd3, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_SEVEN, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_SEVEN, 1'b0, 1, ow(8'hFF, 1'b1, 1'b0, 1'b1, 16'd1), '0, '0},
			// \x with no digits, then the closing quote
			'{sed_pkg::CH_BSLASH, 1'b0, 0, '0, '0, '0},
			'{sed_pkg::CH_LO_X, 1'b0, 0, '0, '0, '0},
			'{sed_pkg::CH_QUOTE, 1'b0, 3,
				ow(sed_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 16'd1),
				ow(sed_pkg::CH_LO_X, 1'b1, 1'b0, 1'b0, 16'd1),
				ow(8'h00, 1'b0, 1'b1, 1'b1, 16'd1)},
			'{sed_pkg::CH_BSLASH, 1'b0, -1, '0, '0, '0},
			'{sed_pkg::CH_SEVEN, 1'b0, -1, '0, '0, '0},
			'{8'hA5, 1'b1, 2, ow(8'h07, 1'b1, 1'b0, 1'b0, 16'd0),
				ow(8'h00, 1'b0, 1'b1, 1'b1, 16'd0), '0},
			'{sed_pkg::CH_QUOTE, 1'b0, 1, ow(8'h00, 1'b0, 1'b1, 1'b1, 16'd0), '0, '0},
			'{sed_pkg::CH_BSLASH, 1'b0, 0, '0, '0, '0},
			'{8'h5A, 1'b1, 2, ow(sed_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 16'd0),
				ow(8'h00, 1'b0, 1'b1, 1'b1, 16'd0), '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_word(dir_tab[i].b, dir_tab[i].eoi, dir_tab[i].n,
				{dir_tab[i].r2, dir_tab[i].r1, dir_tab[i].r0});

		while (n_words < N_DIR + N_RANDOM)
			random_string();

		din_if.valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d input words, checked %0d output words, %0d strings closed.",
			n_words, n_checked, n_closed);
		$display("Plain bytes, escapes, digit runs and end-of-input flushes exercised.");
		if (errors == 0 && pending_out.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
design/sed_pkg.sv
design/sed_word_if.sv
design/string_escape_decoder.sv
dv/testbench.sv
